/* rtl/aedl_pkg.sv */
// Shared constants and types for the audio echo delay line.
`default_nettype none
package aedl_pkg;

	localparam int DELAY_DEPTH = 65536;
	localparam int SAMPLE_WIDTH = 16;
	localparam int ADDR_W = $clog2(DELAY_DEPTH);
	localparam int CNT_W = ADDR_W + 1;
	localparam int LEN_W = 17;
	localparam int GAIN_W = 16;
	localparam int GAIN_FRAC = 15;
	localparam int CHAN_W = 2;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 17;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	localparam logic [CFG_INDEX_W-1:0] REG_DELAY_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ECHO_GAIN = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

	typedef struct packed {
		logic vld;
		logic echo_on;
		logic stereo;
	} aedl_ctl_t;

endpackage
`default_nettype wire

/* rtl/aedl_store.sv */
// Delay store: single-port synchronous RAM, read-first, registered read data.
`default_nettype none
module aedl_store import aedl_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic [ADDR_W-1:0]       addr,
	input  wire logic [SAMPLE_WIDTH-1:0] wdata,
	output logic      [SAMPLE_WIDTH-1:0] rdata
);

	logic [SAMPLE_WIDTH-1:0] mem [DELAY_DEPTH];

	// old contents come out when the same entry is written
	always_ff @(posedge clk) begin
		if (en) begin
			rdata <= mem[addr];
			mem[addr] <= wdata;
		end
	end

endmodule
`default_nettype wire

/* rtl/aedl_mix.sv */
// Echo mixer: Q1.15 scaling stage then add and saturate.
`default_nettype none
module aedl_mix import aedl_pkg::*; (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire aedl_ctl_t                      ctl_s1,
	input  wire logic signed [SAMPLE_WIDTH-1:0] left_s1,
	input  wire logic signed [SAMPLE_WIDTH-1:0] right_s1,
	input  wire logic signed [SAMPLE_WIDTH-1:0] delayed_s1,
	input  wire logic        [GAIN_W-1:0]       gain,
	output logic                                res_valid,
	output logic             [SAMPLE_WIDTH-1:0] res_left,
	output logic             [SAMPLE_WIDTH-1:0] res_right
);

	localparam int PROD_W = SAMPLE_WIDTH + GAIN_W + 1;
	localparam int ECHO_W = PROD_W - GAIN_FRAC;
	localparam int SUM_W = ECHO_W + 1;
	localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-(1 << (SAMPLE_WIDTH - 1)));

	aedl_ctl_t                      ctl_s2;
	logic signed [PROD_W-1:0]       product_s2;
	logic signed [SAMPLE_WIDTH-1:0] left_s2;
	logic signed [SAMPLE_WIDTH-1:0] right_s2;
	logic signed [ECHO_W-1:0]       echo;
	logic signed [SUM_W-1:0]        sum_l;
	logic signed [SUM_W-1:0]        sum_r;

	function automatic logic [SAMPLE_WIDTH-1:0] sat(input logic signed [SUM_W-1:0] v);
		logic [SAMPLE_WIDTH-1:0] r;
		if (v > SUM_MAX) begin
			r = SUM_MAX[SAMPLE_WIDTH-1:0];
		end else if (v < SUM_MIN) begin
			r = SUM_MIN[SAMPLE_WIDTH-1:0];
		end else begin
			r = v[SAMPLE_WIDTH-1:0];
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		left_s2 <= left_s1;
		right_s2 <= right_s1;
		if (ctl_s1.echo_on) begin
			product_s2 <= PROD_W'(delayed_s1) * $signed({1'b0, gain});
		end else begin
			product_s2 <= '0;
		end
	end

	// arithmetic shift floors toward minus infinity
	assign echo = product_s2[PROD_W-1:GAIN_FRAC];
	assign sum_l = SUM_W'(left_s2) + SUM_W'(echo);
	assign sum_r = SUM_W'(right_s2) + SUM_W'(echo);

	assign res_valid = ctl_s2.vld;
	assign res_left = sat(sum_l);
	assign res_right = ctl_s2.stereo ? sat(sum_r) : '0;

endmodule
`default_nettype wire

/* rtl/aedl_out_fifo.sv */
// Small output queue that decouples the pipeline from the downstream stall.
`default_nettype none
module aedl_out_fifo import aedl_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic [2*SAMPLE_WIDTH-1:0]   wr_data,
	output logic                             rd_valid,
	input  wire logic                        rd_ready,
	output logic      [2*SAMPLE_WIDTH-1:0]   rd_data,
	output logic      [FIFO_AW:0]            count
);

	logic [2*SAMPLE_WIDTH-1:0] slots_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]        wr_ptr_q;
	logic [FIFO_AW-1:0]        rd_ptr_q;
	logic [FIFO_AW:0]          count_q;
	logic                      pop;

	assign rd_valid = (count_q != '0);
	assign pop = rd_valid && rd_ready;
	assign rd_data = slots_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			count_q <= count_q + (FIFO_AW + 1)'(wr_en) - (FIFO_AW + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

/* rtl/audio_echo_delay_line_core.sv */
// Audio echo delay line core: top level with config registers and store pointer.
// Path: stage 1 (store read), stage 2 (scaled echo), then the output queue onto m_tdata.
// Throughput: one frame per cycle unless stalled; a read-first store access if active.
// Reset: registers go to length 0, gain 0, two channels; pointer to zero.
// The store is not swept: a wrap flag marks whether the entry under the pointer has been
// written since the last length write, and unwritten entries read as zero.
`default_nettype none
module audio_echo_delay_line_core import aedl_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [2*SAMPLE_WIDTH-1:0] s_tdata, // left_in [15:0], right_in [31:16]
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic      [2*SAMPLE_WIDTH-1:0] m_tdata, // left_out [15:0], right_out [31:16]
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

	// configuration registers
	logic [LEN_W-1:0]  delay_length_q;
	logic [GAIN_W-1:0] echo_gain_q;
	logic [CHAN_W-1:0] channel_count_q;

	// store pointer and "whole ring written once" flag
	logic [ADDR_W-1:0] ptr_q;
	logic              wrapped_q;

	logic [CNT_W-1:0]  len_eff;
	logic              active;
	logic              stereo;
	logic              accept;
	logic              mem_en;
	logic              ptr_wrap;
	logic [ADDR_W-1:0] ptr_next;
	logic              len_write;

	logic signed [SAMPLE_WIDTH-1:0] left_in;
	logic signed [SAMPLE_WIDTH-1:0] right_in;

	// stage 1: store read data lines up with these
	aedl_ctl_t                      ctl_s1;
	logic signed [SAMPLE_WIDTH-1:0] left_s1;
	logic signed [SAMPLE_WIDTH-1:0] right_s1;
	logic        [SAMPLE_WIDTH-1:0] delayed_s1;

	logic                    res_valid;
	logic [SAMPLE_WIDTH-1:0] res_left;
	logic [SAMPLE_WIDTH-1:0] res_right;
	logic [FIFO_AW:0]        fifo_count;
	logic [FIFO_AW:0]        occupancy;

	assign cfg_ready = 1'b1;
	assign len_write = cfg_valid && (cfg_index == REG_DELAY_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_length_q <= '0;
			echo_gain_q <= '0;
			channel_count_q <= CHAN_W'(2);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DELAY_LENGTH:  delay_length_q <= cfg_data[LEN_W-1:0];
				REG_ECHO_GAIN:     echo_gain_q <= cfg_data[GAIN_W-1:0];
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data[CHAN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// lengths beyond the store act as the full store
	always_comb begin
		if (32'(delay_length_q) > 32'(DELAY_DEPTH)) begin
			len_eff = CNT_W'(DELAY_DEPTH);
		end else begin
			len_eff = CNT_W'(delay_length_q);
		end
	end

	assign active = (len_eff != '0) && (echo_gain_q != '0);
	assign stereo = channel_count_q[1]; // 0,1 mono; 2,3 stereo

	assign left_in = s_tdata[SAMPLE_WIDTH-1:0];
	assign right_in = s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];

	// requests in flight plus queued results never exceed the queue depth
	assign occupancy = fifo_count + (FIFO_AW + 1)'(ctl_s1.vld) + (FIFO_AW + 1)'(res_valid);
	assign s_tready = (occupancy < (FIFO_AW + 1)'(FIFO_DEPTH));
	assign accept = s_tvalid && s_tready;
	assign mem_en = accept && active;

	assign ptr_wrap = (({1'b0, ptr_q} + CNT_W'(1)) >= len_eff);
	assign ptr_next = ptr_wrap ? '0 : ptr_q + ADDR_W'(1);

	// length write empties the store logically: pointer home, wrap flag cleared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			wrapped_q <= 1'b0;
		end else if (len_write) begin
			ptr_q <= '0;
			wrapped_q <= 1'b0;
		end else if (mem_en) begin
			ptr_q <= ptr_next;
			if (ptr_wrap) begin
				wrapped_q <= 1'b1;
			end
		end
	end

	aedl_store u_store (
		.clk   (clk),
		.en    (mem_en),
		.addr  (ptr_q),
		.wdata (stereo ? right_in : left_in),
		.rdata (delayed_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.vld <= accept;
			ctl_s1.echo_on <= active && wrapped_q;
			ctl_s1.stereo <= stereo;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			left_s1 <= left_in;
			right_s1 <= right_in;
		end
	end

	aedl_mix u_mix (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_s1     (ctl_s1),
		.left_s1    (left_s1),
		.right_s1   (right_s1),
		.delayed_s1 ($signed(delayed_s1)),
		.gain       (echo_gain_q),
		.res_valid  (res_valid),
		.res_left   (res_left),
		.res_right  (res_right)
	);

	aedl_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (res_valid),
		.wr_data  ({res_right, res_left}),
		.rd_valid (m_tvalid),
		.rd_ready (m_tready),
		.rd_data  (m_tdata),
		.count    (fifo_count)
	);

endmodule
`default_nettype wire
